// File: hdl/u8hx_pkg.sv
// Shared types, codes and decode helpers for the UTF-8 and hex escape decoder.
package u8hx_pkg;

  // Decoder mode codes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_UTF8   = 3'd1;
  localparam logic [2:0] MODE_WANT_X = 3'd2;
  localparam logic [2:0] MODE_FIRST  = 3'd3;
  localparam logic [2:0] MODE_DIGITS = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_CHAR = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Byte constants
  localparam logic [7:0] BYTE_NUL    = 8'h00;
  localparam logic [7:0] BYTE_NL     = 8'h0A;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_X      = 8'h78;
  localparam logic [5:0] CONT_MASK   = 6'h3F;

  // One result word
  typedef struct packed {
    logic [31:0] cp;
    logic [1:0]  st;
    logic        last;
  } res_t;

  // Outcome of decoding a byte from idle
  typedef struct packed {
    logic        hit;
    logic [31:0] cp;
    logic [1:0]  st;
    logic [2:0]  mode;
    logic        load;
    logic [31:0] acc;
    logic [2:0]  rem;
  } start_t;

  // Hex digit value, top bit flags a valid digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // Start of a new character from idle
  function automatic start_t start_char(input logic [7:0] b, input logic eoi);
    start_t s;
    logic [2:0] n;
    s      = '0;
    s.mode = MODE_IDLE;
    n      = 3'd1;
    if (eoi || b == BYTE_NUL || b == BYTE_NL) begin
      s.hit = 1'b1;
      s.st  = ST_END;
    end else if (b == BYTE_BSLASH) begin
      s.mode = MODE_WANT_X;
    end else if (b < 8'h80) begin
      s.hit = 1'b1;
      s.cp  = {24'd0, b};
      s.st  = ST_CHAR;
    end else if (b < 8'hC0) begin
      s.hit = 1'b1;
      s.cp  = {26'd0, b[5:0]};
      s.st  = ST_CHAR;
    end else if (b >= 8'hFE) begin
      s.hit = 1'b1;
      s.st  = ST_ERR;
    end else begin
      if (b < 8'hE0) begin
        n = 3'd1;
      end else if (b < 8'hF0) begin
        n = 3'd2;
      end else if (b < 8'hF8) begin
        n = 3'd3;
      end else if (b < 8'hFC) begin
        n = 3'd4;
      end else begin
        n = 3'd5;
      end
      s.load = 1'b1;
      s.acc  = {26'd0, b[5:0] & (CONT_MASK >> n)};
      s.rem  = n;
      s.mode = MODE_UTF8;
    end
    return s;
  endfunction

endpackage

// File: hdl/utf8_and_hex_escape_decoder.sv
// Top level of the UTF-8 and hex escape decoder.
//
// Input stream: one word per byte. s_axis_tdata carries the raw byte and
// s_axis_tuser marks the end of the stream (the byte is then ignored).
// Output stream: m_axis_tdata is the decoded code point, m_axis_tuser the
// status (character, end of text or line, error) and m_axis_tlast flags the
// final result caused by one input word.
// A word taken is held in the input register and decoded from there; its
// results are written into the result buffer, which offers them in turn.
// Throughput: one input word per cycle while the receiver does not stall
// and each word causes at most one result; a word that ends a hex escape
// and then gives a further result fills both entries of the result buffer.
// Reset returns the decoder to idle and empties both the input register and
// the result buffer. When the receiver stalls, results wait in the buffer;
// the input register keeps taking words until the buffer cannot hold the
// results of the word waiting to be decoded.
module utf8_and_hex_escape_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte [7:0]
  input  logic        s_axis_tuser,   // end_of_input [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // code_point [31:0]
  output logic [1:0]  m_axis_tuser,   // status [1:0]
  output logic        m_axis_tlast    // last_of_run
);

  // Input register
  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;

  // Decoder state
  logic [2:0]  mode_q, mode_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  rem_q, rem_d;
  logic        sat_q, sat_d;

  // Result buffer
  u8hx_pkg::res_t ob_q [2];
  u8hx_pkg::res_t ob_d [2];
  logic [1:0]     cnt_q, cnt_d;

  logic              pop, fire, room;
  logic [1:0]        cnt_after;
  logic [1:0]        nres;
  u8hx_pkg::res_t    r0, r1;
  u8hx_pkg::start_t  sc;
  logic [4:0]        hv;

  assign pop       = (cnt_q != 2'd0) && m_axis_tready;
  assign cnt_after = cnt_q - {1'b0, pop};
  assign room      = ({1'b0, cnt_after} + {1'b0, nres}) <= 3'd2;
  assign fire      = in_v_q && room;
  assign s_axis_tready = !in_v_q || fire;

  // Decode the registered word
  always_comb begin
    sc     = u8hx_pkg::start_char(in_byte_q, in_eoi_q);
    hv     = in_eoi_q ? 5'd0 : u8hx_pkg::hex_value(in_byte_q);
    mode_d = mode_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    sat_d  = sat_q;
    nres   = 2'd0;
    r0     = '0;
    r1     = '0;
    case (mode_q)
      u8hx_pkg::MODE_UTF8: begin
        if (in_eoi_q) begin
          mode_d = u8hx_pkg::MODE_IDLE;
          rem_d  = 3'd0;
          nres   = 2'd1;
          r0.st  = u8hx_pkg::ST_ERR;
        end else begin
          acc_d = {acc_q[25:0], in_byte_q[5:0]};
          rem_d = rem_q - 3'd1;
          if (rem_q == 3'd1) begin
            mode_d = u8hx_pkg::MODE_IDLE;
            nres   = 2'd1;
            r0.cp  = acc_d;
            r0.st  = u8hx_pkg::ST_CHAR;
          end
        end
      end
      u8hx_pkg::MODE_WANT_X: begin
        if (!in_eoi_q && in_byte_q == u8hx_pkg::BYTE_X) begin
          mode_d = u8hx_pkg::MODE_FIRST;
          acc_d  = 32'd0;
          sat_d  = 1'b0;
        end else begin
          mode_d = u8hx_pkg::MODE_IDLE;
          nres   = 2'd1;
          r0.st  = u8hx_pkg::ST_ERR;
        end
      end
      u8hx_pkg::MODE_FIRST: begin
        if (hv[4]) begin
          mode_d = u8hx_pkg::MODE_DIGITS;
          acc_d  = {28'd0, hv[3:0]};
          sat_d  = 1'b0;
        end else begin
          mode_d = u8hx_pkg::MODE_IDLE;
          nres   = 2'd1;
          r0.st  = u8hx_pkg::ST_ERR;
        end
      end
      u8hx_pkg::MODE_DIGITS: begin
        if (hv[4]) begin
          if (sat_q || acc_q[31:28] != 4'd0) begin
            sat_d = 1'b1;
            acc_d = 32'hFFFF_FFFF;
          end else begin
            acc_d = {acc_q[27:0], hv[3:0]};
          end
        end else begin
          // digit run closed: value first, then the byte from idle
          r0.cp  = acc_q;
          r0.st  = u8hx_pkg::ST_CHAR;
          sat_d  = 1'b0;
          mode_d = sc.mode;
          if (sc.load) begin
            acc_d = sc.acc;
            rem_d = sc.rem;
          end
          r1.cp  = sc.cp;
          r1.st  = sc.st;
          nres   = sc.hit ? 2'd2 : 2'd1;
        end
      end
      default: begin
        mode_d = sc.mode;
        if (sc.load) begin
          acc_d = sc.acc;
          rem_d = sc.rem;
        end
        r0.cp = sc.cp;
        r0.st = sc.st;
        nres  = sc.hit ? 2'd1 : 2'd0;
      end
    endcase
    r0.last = (nres == 2'd1);
    r1.last = 1'b1;
  end

  // Result buffer update: shift on pop, append behind what remains
  always_comb begin
    ob_d[0] = ob_q[0];
    ob_d[1] = ob_q[1];
    cnt_d   = cnt_after;
    if (pop) begin
      ob_d[0] = ob_q[1];
    end
    if (fire && nres != 2'd0) begin
      if (cnt_after == 2'd0) begin
        ob_d[0] = r0;
        ob_d[1] = r1;
      end else begin
        ob_d[1] = r0;
      end
      cnt_d = cnt_after + nres;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      cnt_q  <= 2'd0;
      mode_q <= u8hx_pkg::MODE_IDLE;
      acc_q  <= 32'd0;
      rem_q  <= 3'd0;
      sat_q  <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      cnt_q <= cnt_d;
      if (fire) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        rem_q  <= rem_d;
        sat_q  <= sat_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser;
    end
    ob_q[0] <= ob_d[0];
    ob_q[1] <= ob_d[1];
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = ob_q[0].cp;
  assign m_axis_tuser  = ob_q[0].st;
  assign m_axis_tlast  = ob_q[0].last;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("result buffer overfilled");

  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && nres == 2'd2) |=> (cnt_q == 2'd2))
    else $error("double result not fully buffered");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == u8hx_pkg::MODE_DIGITS && sat_q) |-> (acc_q == 32'hFFFF_FFFF))
    else $error("saturated hex value not all ones");

  a_utf8_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == u8hx_pkg::MODE_UTF8) |-> (rem_q != 3'd0))
    else $error("UTF-8 form with no continuation bytes due");

endmodule

// File: dv/utf8_and_hex_escape_decoder_tb.sv
// Self-checking testbench for the UTF-8 and hex escape decoder.
`timescale 1ns / 1ps

module utf8_and_hex_escape_decoder_tb;

  // One pending input word
  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic       pause;
  } in_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // in_byte [7:0]
  logic        s_axis_tuser = 1'b0;   // end_of_input [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // code_point [31:0]
  logic [1:0]  m_axis_tuser;          // status [1:0]
  logic        m_axis_tlast;          // last_of_run

  utf8_and_hex_escape_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  in_word_t       pending_words[$];
  u8hx_pkg::res_t expected_chars[$];
  bit             pause_req = 1'b0;
  bit             word_taken = 1'b0;
  int             fails = 0;
  int             tx_wait = 0;
  int             rx_wait = 0;
  bit             tx_quiet = 1'b0;
  bit             rx_quiet = 1'b0;

  // Decoder state as predicted
  logic [2:0]     mode_q = u8hx_pkg::MODE_IDLE;
  logic [31:0]    acc_q = 32'd0;
  logic [2:0]     rem_q = 3'd0;
  logic           sat_q = 1'b0;
  u8hx_pkg::res_t staged[2];
  int             n_staged;

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic int digit_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - 48;
    if (b >= "a" && b <= "f") return int'(b) - 87;
    if (b >= "A" && b <= "F") return int'(b) - 55;
    return -1;
  endfunction

  task automatic emit(input logic [31:0] cp, input logic [1:0] st);
    staged[n_staged] = {cp, st, 1'b0};
    n_staged++;
  endtask

  // New character from idle
  task automatic begin_char(input logic [7:0] b, input logic eoi);
    logic [2:0] n;
    mode_q = u8hx_pkg::MODE_IDLE;
    if (eoi || b == u8hx_pkg::BYTE_NUL || b == u8hx_pkg::BYTE_NL) begin
      emit(32'd0, u8hx_pkg::ST_END);
    end else if (b == u8hx_pkg::BYTE_BSLASH) begin
      mode_q = u8hx_pkg::MODE_WANT_X;
    end else if (!b[7]) begin
      emit({24'd0, b}, u8hx_pkg::ST_CHAR);
    end else if (!b[6]) begin
      emit({26'd0, b[5:0]}, u8hx_pkg::ST_CHAR);
    end else if (b[7:1] == 7'h7F) begin
      emit(32'd0, u8hx_pkg::ST_ERR);
    end else begin
      // continuation count from the run of leading ones
      n = !b[5] ? 3'd1 : !b[4] ? 3'd2 : !b[3] ? 3'd3 : !b[2] ? 3'd4 : 3'd5;
      acc_q  = {26'd0, b[5:0] & (6'h3F >> n)};
      rem_q  = n;
      mode_q = u8hx_pkg::MODE_UTF8;
    end
  endtask

  // Work out the results of one accepted word and queue them
  task automatic decode_word(input logic [7:0] b, input logic eoi);
    int             d;
    u8hx_pkg::res_t r;
    n_staged = 0;
    d = eoi ? -1 : digit_of(b);
    case (mode_q)
      u8hx_pkg::MODE_UTF8: begin
        if (eoi) begin
          mode_q = u8hx_pkg::MODE_IDLE;
          rem_q  = 3'd0;
          emit(32'd0, u8hx_pkg::ST_ERR);
        end else begin
          acc_q = {acc_q[25:0], b[5:0]};
          rem_q = rem_q - 3'd1;
          if (rem_q == 3'd0) begin
            mode_q = u8hx_pkg::MODE_IDLE;
            emit(acc_q, u8hx_pkg::ST_CHAR);
          end
        end
      end
      u8hx_pkg::MODE_WANT_X: begin
        if (!eoi && b == u8hx_pkg::BYTE_X) begin
          mode_q = u8hx_pkg::MODE_FIRST;
          acc_q  = 32'd0;
          sat_q  = 1'b0;
        end else begin
          mode_q = u8hx_pkg::MODE_IDLE;
          emit(32'd0, u8hx_pkg::ST_ERR);
        end
      end
      u8hx_pkg::MODE_FIRST: begin
        if (d < 0) begin
          mode_q = u8hx_pkg::MODE_IDLE;
          emit(32'd0, u8hx_pkg::ST_ERR);
        end else begin
          acc_q  = {28'd0, d[3:0]};
          sat_q  = 1'b0;
          mode_q = u8hx_pkg::MODE_DIGITS;
        end
      end
      u8hx_pkg::MODE_DIGITS: begin
        if (d >= 0) begin
          // saturate once a digit would push bits past the top
          if (sat_q || acc_q[31:28] != 4'd0) begin
            sat_q = 1'b1;
            acc_q = 32'hFFFF_FFFF;
          end else begin
            acc_q = {acc_q[27:0], d[3:0]};
          end
        end else begin
          emit(acc_q, u8hx_pkg::ST_CHAR);
          sat_q = 1'b0;
          begin_char(b, eoi);
        end
      end
      default: begin
        begin_char(b, eoi);
      end
    endcase
    for (int i = 0; i < n_staged; i++) begin
      r = staged[i];
      r.last = (i == n_staged - 1);
      expected_chars.push_back(r);
    end
  endtask

  task automatic flag_fail(input string msg);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  task automatic add_word(input logic [7:0] b, input logic eoi);
    pending_words.push_back('{b: b, eoi: eoi, pause: pause_req});
    pause_req = 1'b0;
  endtask

  // Input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || word_taken) begin
      if (word_taken) begin
        word_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
        tx_wait = draw_wait(tx_quiet);
      end
      if (tx_wait > 0) begin
        tx_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].pause && expected_chars.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata  <= pending_words[0].b;
        s_axis_tuser  <= pending_words[0].eoi;
        s_axis_tvalid <= 1'b1;
        void'(pending_words.pop_front());
      end
    end
  end

  // Output stall control
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: check results, then predict for words taken at this edge
  always @(posedge clk_i) begin : mon
    u8hx_pkg::res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        rx_wait = draw_wait(rx_quiet);
        if (expected_chars.size() == 0) begin
          flag_fail($sformatf("unexpected word cp %h st %0d last %0d",
                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.cp || m_axis_tuser !== want.st ||
              m_axis_tlast !== want.last) begin
            flag_fail($sformatf("mismatch cp %h/%h st %0d/%0d last %0d/%0d (exp/act)",
                                want.cp, m_axis_tdata, want.st, m_axis_tuser,
                                want.last, m_axis_tlast));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decode_word(s_axis_tdata, s_axis_tuser);
        word_taken = 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : run
    int          kind;
    int          len;
    int          v;
    logic [7:0]  c;
    int          target;
    string       hex_run;

    hex_run = "1aBcDeF09";
    // plain bytes, ends and bad leads
    add_word(8'h41, 1'b0);
    add_word(u8hx_pkg::BYTE_NUL, 1'b0);
    add_word(u8hx_pkg::BYTE_NL, 1'b0);
    add_word(8'h80, 1'b0);
    add_word(8'hFE, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'hFF, 1'b1);
    // two-byte form, then a form cut short by the end mark
    add_word(8'hC3, 1'b0);
    add_word(8'hA9, 1'b0);
    add_word(8'hE2, 1'b0);
    add_word(8'h00, 1'b1);
    // saturating escape ended by a backslash, then a missing x
    add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
    add_word(u8hx_pkg::BYTE_X, 1'b0);
    foreach (hex_run[i]) add_word(hex_run[i], 1'b0);
    add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
    add_word("q", 1'b0);
    // no digit after x, end after x, end after backslash
    add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
    add_word(u8hx_pkg::BYTE_X, 1'b0);
    add_word("g", 1'b0);
    add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
    add_word(u8hx_pkg::BYTE_X, 1'b0);
    add_word(8'h00, 1'b1);
    add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
    add_word(8'h5A, 1'b1);
    // digit runs ended by newline and by the end mark
    add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
    add_word(u8hx_pkg::BYTE_X, 1'b0);
    add_word("5", 1'b0);
    add_word(u8hx_pkg::BYTE_NL, 1'b0);
    add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
    add_word(u8hx_pkg::BYTE_X, 1'b0);
    add_word("0", 1'b0);
    add_word(8'hFF, 1'b1);

    // random part, mostly well-formed sequences
    pause_req = 1'b1;
    target = 650;
    while (pending_words.size() < target) begin
      if ($urandom_range(0, 59) == 0) pause_req = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        add_word(8'($urandom_range(0, 127)), 1'b0);
      end else if (kind < 55) begin
        // UTF-8 form of 2 to 6 bytes, sometimes cut short
        len = $urandom_range(2, 6);
        add_word((8'hFF << (8 - len)) | (8'($urandom) & (8'h7F >> len)), 1'b0);
        for (int i = 1; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            add_word(8'($urandom), 1'b1);
            break;
          end
          if ($urandom_range(0, 9) == 0) add_word(8'($urandom), 1'b0);
          else add_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        end
      end else if (kind < 78) begin
        // hex escape with a mixed-case digit run
        add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
        add_word(u8hx_pkg::BYTE_X, 1'b0);
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          v = $urandom_range(0, 15);
          if (v < 10) c = 8'(48 + v);
          else c = 8'((($urandom_range(0, 1) == 0) ? 65 : 97) + v - 10);
          add_word(c, 1'b0);
        end
        v = $urandom_range(0, 99);
        if (v < 40) add_word(8'($urandom), 1'b0);
        else if (v < 60) add_word(8'($urandom), 1'b1);
        else if (v < 75) add_word(u8hx_pkg::BYTE_NL, 1'b0);
        else if (v < 90) add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
        else add_word(u8hx_pkg::BYTE_NUL, 1'b0);
      end else if (kind < 90) begin
        add_word(8'($urandom), 1'b0);
      end else if (kind < 94) begin
        add_word(8'($urandom), 1'b1);
      end else begin
        // broken escapes
        add_word(u8hx_pkg::BYTE_BSLASH, 1'b0);
        v = $urandom_range(0, 2);
        if (v == 0) begin
          add_word(8'($urandom), $urandom_range(0, 3) == 0);
        end else begin
          add_word(u8hx_pkg::BYTE_X, 1'b0);
          add_word(8'($urandom_range(103, 255)), v == 2);
        end
      end
    end

    // reset
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain
    while (pending_words.size() != 0 || s_axis_tvalid || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (24) @(posedge clk_i);

    if (fails == 0 && expected_chars.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: utf8_and_hex_escape_decoder.f
hdl/u8hx_pkg.sv
hdl/utf8_and_hex_escape_decoder.sv
dv/utf8_and_hex_escape_decoder_tb.sv
